FILE: sv/hra_pkg.sv
// Shared types, widths and arithmetic helpers for the heater runtime accumulator.
// No dependencies; every other file refers to this package by scoped names.

package hra_pkg;

    // Field widths.
    localparam int STAMP_W = 40;
    localparam int TOTAL_W = 32;

    // Default depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Operation codes of an input word.
    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_EVENT  = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    // Event codes of a log event.
    typedef enum logic [3:0] {
        EV_GAS_ON     = 4'd0,
        EV_GAS_OFF    = 4'd1,
        EV_PELLET_ON  = 4'd2,
        EV_PELLET_OFF = 4'd3,
        EV_MINIMUM    = 4'd4,
        EV_MODULATION = 4'd5,
        EV_HOT        = 4'd6,
        EV_COLD       = 4'd7
    } t_evt;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        t_op                  op;
        t_evt                 evt;
        logic [STAMP_W-1:0]   stamp;
        logic                 init_pellet_on;
        logic                 init_pellet_low;
        logic                 init_gas_on;
        logic [TOTAL_W-1:0]   init_pellet_total;
        logic [TOTAL_W-1:0]   init_low_total;
        logic [TOTAL_W-1:0]   init_gas_total;
    } t_cmd;

    // Accumulator update produced by the span stage. On a start the delta
    // fields carry the totals to load.
    typedef struct packed {
        logic                 load;
        logic                 finish;
        logic                 add_pellet;
        logic                 add_low;
        logic                 add_gas;
        logic                 still_pellet;
        logic                 still_low;
        logic                 still_gas;
        logic [TOTAL_W-1:0]   d_pellet;
        logic [TOTAL_W-1:0]   d_low;
        logic [TOTAL_W-1:0]   d_gas;
    } t_span_op;

    // Length of the span from since to t, zero when time ran backwards,
    // clamped to the total width.
    function automatic logic [TOTAL_W-1:0] span_clamp(input logic [STAMP_W-1:0] since,
                                                      input logic [STAMP_W-1:0] t);
        logic [STAMP_W:0]   diff;
        logic [TOTAL_W-1:0] res;
        diff = {1'b0, t} - {1'b0, since};
        if (diff[STAMP_W]) begin
            res = '0;
        end else if (|diff[STAMP_W-1:TOTAL_W]) begin
            res = '1;
        end else begin
            res = diff[TOTAL_W-1:0];
        end
        return res;
    endfunction

    // Saturating add of two totals.
    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

endpackage

FILE: sv/heater_runtime_accumulator.sv
// Top level of the heater runtime accumulator: front part, command queue and
// back part. Depends on hra_pkg, hra_front, hra_queue and hra_back.
//
//  Channel  | Handshake          | Word
//  ---------+--------------------+---------------------------------------------
//  input    | i_valid / o_ready  | operation, stamp, event code, start values
//  result   | o_valid / i_ready  | three totals and three still-on bits
//
// One input word is taken per cycle, sustained, for every operation, while the queue has room.
// A finish passes the queue, the span stage register and the accumulator stage
// into the result register, where its result shows.
// Reset is synchronous and clears the since times, hot flag, totals and queue.
// The result register holds a word until it is taken; a finish behind it waits
// in the span stage, and o_ready falls once the QUEUE_DEPTH-entry queue fills.

module heater_runtime_accumulator #(
    parameter int QUEUE_DEPTH = hra_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_operation,
    input  logic [hra_pkg::STAMP_W-1:0] i_stamp,
    input  logic [3:0]                  i_event_code,
    input  logic                        i_init_pellet_on,
    input  logic                        i_init_pellet_low,
    input  logic                        i_init_gas_on,
    input  logic [hra_pkg::TOTAL_W-1:0] i_init_pellet_total,
    input  logic [hra_pkg::TOTAL_W-1:0] i_init_low_total,
    input  logic [hra_pkg::TOTAL_W-1:0] i_init_gas_total,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hra_pkg::TOTAL_W-1:0] o_pellet_total,
    output logic [hra_pkg::TOTAL_W-1:0] o_low_total,
    output logic [hra_pkg::TOTAL_W-1:0] o_gas_total,
    output logic                        o_pellet_still_on,
    output logic                        o_low_still_on,
    output logic                        o_gas_still_on
);

    logic          w_push, w_full, w_pop, w_q_valid;
    hra_pkg::t_cmd w_push_cmd, w_q_cmd;

    // Classify incoming words.
    hra_front u_front (
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_operation         (i_operation),
        .i_stamp             (i_stamp),
        .i_event_code        (i_event_code),
        .i_init_pellet_on    (i_init_pellet_on),
        .i_init_pellet_low   (i_init_pellet_low),
        .i_init_gas_on       (i_init_gas_on),
        .i_init_pellet_total (i_init_pellet_total),
        .i_init_low_total    (i_init_low_total),
        .i_init_gas_total    (i_init_gas_total),
        .i_q_full            (w_full),
        .o_push              (w_push),
        .o_cmd               (w_push_cmd)
    );

    // Decouple the two parts.
    hra_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // Carry out the commands.
    hra_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (w_q_valid),
        .i_cmd             (w_q_cmd),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_pellet_total    (o_pellet_total),
        .o_low_total       (o_low_total),
        .o_gas_total       (o_gas_total),
        .o_pellet_still_on (o_pellet_still_on),
        .o_low_still_on    (o_low_still_on),
        .o_gas_still_on    (o_gas_still_on)
    );

endmodule

FILE: sv/hra_front.sv
// Front part: accepts input words, drops those that change nothing and
// classifies the rest into commands for the queue. Depends on hra_pkg.

module hra_front (
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_operation,
    input  logic [hra_pkg::STAMP_W-1:0] i_stamp,
    input  logic [3:0]                  i_event_code,
    input  logic                        i_init_pellet_on,
    input  logic                        i_init_pellet_low,
    input  logic                        i_init_gas_on,
    input  logic [hra_pkg::TOTAL_W-1:0] i_init_pellet_total,
    input  logic [hra_pkg::TOTAL_W-1:0] i_init_low_total,
    input  logic [hra_pkg::TOTAL_W-1:0] i_init_gas_total,
    input  logic                        i_q_full,
    output logic                        o_push,
    output hra_pkg::t_cmd               o_cmd
);

    logic w_keep;

    // The front takes a word whenever the queue has room.
    assign o_ready = !i_q_full;

    // Decide whether the word has any effect at all.
    always_comb begin
        w_keep = 1'b0;
        case (hra_pkg::t_op'(i_operation))
            hra_pkg::OP_START:  w_keep = 1'b1;
            hra_pkg::OP_FINISH: w_keep = 1'b1;
            hra_pkg::OP_EVENT: begin
                case (hra_pkg::t_evt'(i_event_code))
                    hra_pkg::EV_GAS_ON,
                    hra_pkg::EV_GAS_OFF,
                    hra_pkg::EV_PELLET_ON,
                    hra_pkg::EV_PELLET_OFF,
                    hra_pkg::EV_MINIMUM,
                    hra_pkg::EV_MODULATION,
                    hra_pkg::EV_HOT,
                    hra_pkg::EV_COLD: w_keep = 1'b1;
                    default:          w_keep = 1'b0;
                endcase
            end
            default: w_keep = 1'b0;
        endcase
    end

    assign o_push = i_valid && !i_q_full && w_keep;

    // Pack the command.
    always_comb begin
        o_cmd.op                = hra_pkg::t_op'(i_operation);
        o_cmd.evt               = hra_pkg::t_evt'(i_event_code);
        o_cmd.stamp             = i_stamp;
        o_cmd.init_pellet_on    = i_init_pellet_on;
        o_cmd.init_pellet_low   = i_init_pellet_low;
        o_cmd.init_gas_on       = i_init_gas_on;
        o_cmd.init_pellet_total = i_init_pellet_total;
        o_cmd.init_low_total    = i_init_low_total;
        o_cmd.init_gas_total    = i_init_gas_total;
    end

endmodule

FILE: sv/hra_queue.sv
// Short command queue between the front and back parts, a circular buffer
// of registers with a fill count. Depends on hra_pkg.

module hra_queue #(
    parameter int DEPTH = hra_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hra_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output hra_pkg::t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hra_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointer and count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: sv/hra_back.sv
// Back part: a span stage that tracks the since times and the hot flag, an
// accumulator stage with saturating totals, and the result register.
// Depends on hra_pkg.

module hra_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  hra_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hra_pkg::TOTAL_W-1:0] o_pellet_total,
    output logic [hra_pkg::TOTAL_W-1:0] o_low_total,
    output logic [hra_pkg::TOTAL_W-1:0] o_gas_total,
    output logic                        o_pellet_still_on,
    output logic                        o_low_still_on,
    output logic                        o_gas_still_on
);

    localparam int SW = hra_pkg::STAMP_W;
    localparam int TW = hra_pkg::TOTAL_W;

    // Span stage state.
    logic [SW-1:0]     r_pellet_since, n_pellet_since;
    logic [SW-1:0]     r_low_since,    n_low_since;
    logic [SW-1:0]     r_gas_since,    n_gas_since;
    logic              r_hot,          n_hot;
    logic              r_a_valid;
    hra_pkg::t_span_op r_a,            n_a;

    // Accumulator stage and result register.
    logic [TW-1:0]     r_pellet_acc, r_low_acc, r_gas_acc;
    logic [TW-1:0]     w_pellet_new, w_low_new, w_gas_new;
    logic              r_o_valid;
    logic [TW-1:0]     r_o_pellet, r_o_low, r_o_gas;
    logic              r_o_still_p, r_o_still_l, r_o_still_g;

    logic [TW-1:0]     w_d_pellet, w_d_low, w_d_gas;
    logic [SW-1:0]     w_t;
    logic              w_p_on, w_l_on, w_g_on;
    logic              w_b_ready, w_b_fire, w_a_ready;

    // A finish can move on only when the result register is free or drains.
    assign w_b_ready = !r_a.finish || !r_o_valid || i_ready;
    assign w_b_fire  = r_a_valid && w_b_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_pop     = i_q_valid && w_a_ready;

    assign w_t    = i_cmd.stamp;
    assign w_p_on = (r_pellet_since != '0);
    assign w_l_on = (r_low_since != '0);
    assign w_g_on = (r_gas_since != '0);

    // Span lengths from the current since times to the command stamp.
    assign w_d_pellet = hra_pkg::span_clamp(r_pellet_since, w_t);
    assign w_d_low    = hra_pkg::span_clamp(r_low_since, w_t);
    assign w_d_gas    = hra_pkg::span_clamp(r_gas_since, w_t);

    // Span stage: next since times, hot flag and accumulator update.
    always_comb begin
        n_pellet_since = r_pellet_since;
        n_low_since    = r_low_since;
        n_gas_since    = r_gas_since;
        n_hot          = r_hot;
        n_a            = '0;
        n_a.d_pellet   = w_d_pellet;
        n_a.d_low      = w_d_low;
        n_a.d_gas      = w_d_gas;
        case (i_cmd.op)
            hra_pkg::OP_START: begin
                n_pellet_since = i_cmd.init_pellet_on  ? w_t : '0;
                n_low_since    = i_cmd.init_pellet_low ? w_t : '0;
                n_gas_since    = i_cmd.init_gas_on     ? w_t : '0;
                n_hot          = 1'b0;
                n_a.load       = 1'b1;
                n_a.d_pellet   = i_cmd.init_pellet_total;
                n_a.d_low      = i_cmd.init_low_total;
                n_a.d_gas      = i_cmd.init_gas_total;
            end
            hra_pkg::OP_FINISH: begin
                n_pellet_since   = '0;
                n_low_since      = '0;
                n_gas_since      = '0;
                n_hot            = 1'b0;
                n_a.finish       = 1'b1;
                n_a.add_pellet   = w_p_on;
                n_a.add_low      = w_l_on;
                n_a.add_gas      = w_g_on;
                n_a.still_pellet = w_p_on;
                n_a.still_low    = w_l_on;
                n_a.still_gas    = w_g_on;
            end
            hra_pkg::OP_EVENT: begin
                case (i_cmd.evt)
                    hra_pkg::EV_GAS_ON: begin
                        // Gas cannot start while the pellet burner is hot.
                        if (!w_g_on && !r_hot) begin
                            n_gas_since = w_t;
                        end
                    end
                    hra_pkg::EV_GAS_OFF: begin
                        n_a.add_gas = w_g_on;
                        n_gas_since = '0;
                    end
                    hra_pkg::EV_PELLET_ON: begin
                        // A minimum span that was already open restarts with the burner.
                        if (!w_p_on) begin
                            n_pellet_since = w_t;
                            if (w_l_on) begin
                                n_low_since = w_t;
                            end
                        end
                    end
                    hra_pkg::EV_PELLET_OFF: begin
                        n_a.add_pellet = w_p_on;
                        n_a.add_low    = w_l_on;
                        n_pellet_since = '0;
                        n_low_since    = '0;
                    end
                    hra_pkg::EV_MINIMUM: begin
                        if (w_p_on && !w_l_on) begin
                            n_low_since = w_t;
                        end
                    end
                    hra_pkg::EV_MODULATION: begin
                        n_a.add_low = w_l_on;
                        n_low_since = '0;
                    end
                    hra_pkg::EV_HOT: begin
                        n_hot       = 1'b1;
                        n_a.add_gas = w_g_on;
                        n_gas_since = '0;
                    end
                    hra_pkg::EV_COLD: begin
                        n_hot = 1'b0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pellet_since <= '0;
            r_low_since    <= '0;
            r_gas_since    <= '0;
            r_hot          <= 1'b0;
            r_a_valid      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pellet_since <= n_pellet_since;
                r_low_since    <= n_low_since;
                r_gas_since    <= n_gas_since;
                r_hot          <= n_hot;
            end
            if (w_a_ready) begin
                r_a_valid <= o_pop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready) begin
            r_a <= n_a;
        end
    end

    // Accumulator stage: load on start, saturating add where a span closed.
    always_comb begin
        if (r_a.load) begin
            w_pellet_new = r_a.d_pellet;
            w_low_new    = r_a.d_low;
            w_gas_new    = r_a.d_gas;
        end else begin
            w_pellet_new = r_a.add_pellet ? hra_pkg::sat_add(r_pellet_acc, r_a.d_pellet)
                                          : r_pellet_acc;
            w_low_new    = r_a.add_low ? hra_pkg::sat_add(r_low_acc, r_a.d_low) : r_low_acc;
            w_gas_new    = r_a.add_gas ? hra_pkg::sat_add(r_gas_acc, r_a.d_gas) : r_gas_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pellet_acc <= '0;
            r_low_acc    <= '0;
            r_gas_acc    <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (w_b_fire) begin
                r_pellet_acc <= w_pellet_new;
                r_low_acc    <= w_low_new;
                r_gas_acc    <= w_gas_new;
            end
            r_o_valid <= (r_o_valid && !i_ready) || (w_b_fire && r_a.finish);
        end
    end

    // Result register holds its word until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (w_b_fire && r_a.finish) begin
            r_o_pellet  <= w_pellet_new;
            r_o_low     <= w_low_new;
            r_o_gas     <= w_gas_new;
            r_o_still_p <= r_a.still_pellet;
            r_o_still_l <= r_a.still_low;
            r_o_still_g <= r_a.still_gas;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_pellet_total    = r_o_pellet;
    assign o_low_total       = r_o_low;
    assign o_gas_total       = r_o_gas;
    assign o_pellet_still_on = r_o_still_p;
    assign o_low_still_on    = r_o_still_l;
    assign o_gas_still_on    = r_o_still_g;

endmodule

FILE: sv/hra_checker.sv
// Port-level checks for the heater runtime accumulator, bound to the top level.
// Depends on hra_pkg for widths.

module hra_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [hra_pkg::TOTAL_W-1:0] o_pellet_total,
    input logic [hra_pkg::TOTAL_W-1:0] o_low_total,
    input logic [hra_pkg::TOTAL_W-1:0] o_gas_total,
    input logic                        o_pellet_still_on,
    input logic                        o_low_still_on,
    input logic                        o_gas_still_on
);

    // A stalled result keeps its valid and its word.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pellet_total)
            && $stable(o_low_total) && $stable(o_gas_total)
            && $stable(o_pellet_still_on) && $stable(o_low_still_on)
            && $stable(o_gas_still_on))
        else $error("result changed while stalled");

    // The input side only backs up after the result side has stalled.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> $past(o_valid && !i_ready))
        else $error("input ready low without a result stall");

    // Reset empties the result register and the queue.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("reset did not clear result and queue");

endmodule

bind heater_runtime_accumulator hra_checker u_hra_checker (.*);

FILE: verif/tb_heater_runtime_accumulator.sv
// Self-checking testbench for heater_runtime_accumulator: directed intervals, then random
// start/event/finish sequences under sender gaps and receiver stalls.
// Depends on hra_pkg for widths and operation and event codes; needs only the RTL.

module tb_heater_runtime_accumulator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAMP_W   = hra_pkg::STAMP_W;
    localparam int TOTAL_W   = hra_pkg::TOTAL_W;
    localparam int RUN_LIMIT = 400000;
    localparam int TAIL_WAIT = 10;

    localparam logic [1:0]         OP_UNUSED    = 2'd3;
    localparam logic [3:0]         EV_UNUSED_LO = 4'd8;
    localparam logic [3:0]         EV_UNUSED_HI = 4'd15;
    localparam logic [STAMP_W-1:0] STAMP_MAX    = {STAMP_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};

    // One input word as the sender drives it.
    typedef struct {
        logic [1:0]         op;
        logic [STAMP_W-1:0] stamp;
        logic [3:0]         code;
        logic               pellet_lit;
        logic               low_on;
        logic               gas_on;
        logic [TOTAL_W-1:0] pellet_init;
        logic [TOTAL_W-1:0] low_init;
        logic [TOTAL_W-1:0] gas_init;
    } t_heater_word;

    // One result word: totals and on-states at the end of an interval.
    typedef struct {
        logic [TOTAL_W-1:0] pellet_total;
        logic [TOTAL_W-1:0] low_total;
        logic [TOTAL_W-1:0] gas_total;
        logic               pellet_lit;
        logic               low_on;
        logic               gas_on;
    } t_heater_totals;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_operation;
    logic [STAMP_W-1:0] i_stamp;
    logic [3:0]         i_event_code;
    logic               i_init_pellet_on;
    logic               i_init_pellet_low;
    logic               i_init_gas_on;
    logic [TOTAL_W-1:0] i_init_pellet_total;
    logic [TOTAL_W-1:0] i_init_low_total;
    logic [TOTAL_W-1:0] i_init_gas_total;
    logic               o_valid;
    logic               i_ready;
    logic [TOTAL_W-1:0] o_pellet_total;
    logic [TOTAL_W-1:0] o_low_total;
    logic [TOTAL_W-1:0] o_gas_total;
    logic               o_pellet_still_on;
    logic               o_low_still_on;
    logic               o_gas_still_on;

    // Predicted block state.
    logic [STAMP_W-1:0] gas_open_at;
    logic [STAMP_W-1:0] pellet_open_at;
    logic [STAMP_W-1:0] low_open_at;
    logic               burner_hot;
    logic [TOTAL_W-1:0] pellet_sum;
    logic [TOTAL_W-1:0] low_sum;
    logic [TOTAL_W-1:0] gas_sum;

    t_heater_totals pending_totals[$];
    t_heater_totals oldest_totals;

    int error_count;
    int cycle_count;
    int burst_left;
    bit sender_steady;
    int busy_words;
    int pace_mode;
    int pace_left;

    heater_runtime_accumulator i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_operation        (i_operation),
        .i_stamp            (i_stamp),
        .i_event_code       (i_event_code),
        .i_init_pellet_on   (i_init_pellet_on),
        .i_init_pellet_low  (i_init_pellet_low),
        .i_init_gas_on      (i_init_gas_on),
        .i_init_pellet_total(i_init_pellet_total),
        .i_init_low_total   (i_init_low_total),
        .i_init_gas_total   (i_init_gas_total),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_pellet_total     (o_pellet_total),
        .o_low_total        (o_low_total),
        .o_gas_total        (o_gas_total),
        .o_pellet_still_on  (o_pellet_still_on),
        .o_low_still_on     (o_low_still_on),
        .o_gas_still_on     (o_gas_still_on)
    );

    // Clock with a 2 ns period.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Add the span from one stamp to another to a total; a backward span adds nothing,
    // and both the span and the sum clamp at the total width.
    function automatic logic [TOTAL_W-1:0] grow_total(input logic [TOTAL_W-1:0] sum,
                                                      input logic [STAMP_W-1:0] from,
                                                      input logic [STAMP_W-1:0] upto);
        logic [STAMP_W-1:0] span;
        logic [STAMP_W:0]   grown;
        span = (upto >= from) ? upto - from : '0;
        if (span > STAMP_W'(TOTAL_MAX)) begin
            span = STAMP_W'(TOTAL_MAX);
        end
        grown = (STAMP_W + 1)'(sum) + {1'b0, span};
        return (grown > (STAMP_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX : grown[TOTAL_W-1:0];
    endfunction

    // Update the predicted state with one accepted word and queue the totals it produces.
    task automatic account_word(input t_heater_word w);
        t_heater_totals sums;
        case (w.op)
            hra_pkg::OP_START: begin
                pellet_open_at = w.pellet_lit ? w.stamp : '0;
                low_open_at    = w.low_on ? w.stamp : '0;
                gas_open_at    = w.gas_on ? w.stamp : '0;
                pellet_sum     = w.pellet_init;
                low_sum        = w.low_init;
                gas_sum        = w.gas_init;
                burner_hot     = 1'b0;
            end
            hra_pkg::OP_EVENT: begin
                case (w.code)
                    hra_pkg::EV_GAS_ON: begin
                        if (gas_open_at == '0 && !burner_hot) begin
                            gas_open_at = w.stamp;
                        end
                    end
                    hra_pkg::EV_GAS_OFF: begin
                        if (gas_open_at != '0) begin
                            gas_sum     = grow_total(gas_sum, gas_open_at, w.stamp);
                            gas_open_at = '0;
                        end
                    end
                    hra_pkg::EV_PELLET_ON: begin
                        // Lighting the burner restarts a minimum span that was left open.
                        if (pellet_open_at == '0) begin
                            pellet_open_at = w.stamp;
                            if (low_open_at != '0) begin
                                low_open_at = w.stamp;
                            end
                        end
                    end
                    hra_pkg::EV_PELLET_OFF: begin
                        if (pellet_open_at != '0) begin
                            pellet_sum     = grow_total(pellet_sum, pellet_open_at, w.stamp);
                            pellet_open_at = '0;
                        end
                        if (low_open_at != '0) begin
                            low_sum     = grow_total(low_sum, low_open_at, w.stamp);
                            low_open_at = '0;
                        end
                    end
                    hra_pkg::EV_MINIMUM: begin
                        if (pellet_open_at != '0 && low_open_at == '0) begin
                            low_open_at = w.stamp;
                        end
                    end
                    hra_pkg::EV_MODULATION: begin
                        if (low_open_at != '0) begin
                            low_sum     = grow_total(low_sum, low_open_at, w.stamp);
                            low_open_at = '0;
                        end
                    end
                    hra_pkg::EV_HOT: begin
                        burner_hot = 1'b1;
                        if (gas_open_at != '0) begin
                            gas_sum     = grow_total(gas_sum, gas_open_at, w.stamp);
                            gas_open_at = '0;
                        end
                    end
                    hra_pkg::EV_COLD: begin
                        burner_hot = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            hra_pkg::OP_FINISH: begin
                sums.pellet_lit = (pellet_open_at != '0);
                sums.low_on     = (low_open_at != '0);
                sums.gas_on     = (gas_open_at != '0);
                if (sums.pellet_lit) begin
                    pellet_sum = grow_total(pellet_sum, pellet_open_at, w.stamp);
                end
                if (sums.low_on) begin
                    low_sum = grow_total(low_sum, low_open_at, w.stamp);
                end
                if (sums.gas_on) begin
                    gas_sum = grow_total(gas_sum, gas_open_at, w.stamp);
                end
                pellet_open_at    = '0;
                low_open_at       = '0;
                gas_open_at       = '0;
                burner_hot        = 1'b0;
                sums.pellet_total = pellet_sum;
                sums.low_total    = low_sum;
                sums.gas_total    = gas_sum;
                pending_totals.insert(pending_totals.size(), sums);
            end
            default: begin
            end
        endcase
    endtask

    // Drive one word and wait for it to be taken. Between bursts the sender idles for
    // a random number of cycles unless it is in a steady stretch.
    task automatic send_word(input t_heater_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = sender_steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_operation         = w.op;
        i_stamp             = w.stamp;
        i_event_code        = w.code;
        i_init_pellet_on    = w.pellet_lit;
        i_init_pellet_low   = w.low_on;
        i_init_gas_on       = w.gas_on;
        i_init_pellet_total = w.pellet_init;
        i_init_low_total    = w.low_init;
        i_init_gas_total    = w.gas_init;
        i_valid             = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        account_word(w);
        // Unused operations and event codes leave the block untouched.
        if (w.op != OP_UNUSED && !(w.op == hra_pkg::OP_EVENT && w.code >= EV_UNUSED_LO)) begin
            busy_words++;
        end
    endtask

    // A word of the given operation with random values in the fields it does not use.
    function automatic t_heater_word base_word(input logic [1:0] op,
                                               input logic [STAMP_W-1:0] stamp);
        t_heater_word w;
        w.op          = op;
        w.stamp       = stamp;
        w.code        = 4'($urandom_range(0, 15));
        w.pellet_lit  = 1'($urandom_range(0, 1));
        w.low_on      = 1'($urandom_range(0, 1));
        w.gas_on      = 1'($urandom_range(0, 1));
        w.pellet_init = $urandom();
        w.low_init    = $urandom();
        w.gas_init    = $urandom();
        return w;
    endfunction

    task automatic send_start(input logic [STAMP_W-1:0] stamp, input logic pellet_lit,
                              input logic low_on, input logic gas_on,
                              input logic [TOTAL_W-1:0] pellet_init,
                              input logic [TOTAL_W-1:0] low_init,
                              input logic [TOTAL_W-1:0] gas_init);
        t_heater_word w;
        w             = base_word(hra_pkg::OP_START, stamp);
        w.pellet_lit  = pellet_lit;
        w.low_on      = low_on;
        w.gas_on      = gas_on;
        w.pellet_init = pellet_init;
        w.low_init    = low_init;
        w.gas_init    = gas_init;
        send_word(w);
    endtask

    task automatic send_event(input logic [3:0] code, input logic [STAMP_W-1:0] stamp);
        t_heater_word w;
        w      = base_word(hra_pkg::OP_EVENT, stamp);
        w.code = code;
        send_word(w);
    endtask

    task automatic send_finish(input logic [STAMP_W-1:0] stamp);
        send_word(base_word(hra_pkg::OP_FINISH, stamp));
    endtask

    // Hold the input idle until every pending result has been taken.
    task automatic pause_until_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_totals.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    // Events and finishes straight after reset act on the cleared state; a span
    // opened at stamp zero stays closed.
    task automatic test_without_start();
        send_event(hra_pkg::EV_GAS_ON, 40'd5);
        send_event(hra_pkg::EV_PELLET_ON, 40'd0);
        send_finish(40'd12);
        send_finish(40'd20);
        pause_until_drained();
    endtask

    // The pellet, minimum, modulation and gas event codes, the unused codes and the unused operation.
    task automatic test_event_codes();
        t_heater_word w;
        send_start(40'd100, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0);
        send_event(hra_pkg::EV_PELLET_ON, 40'd110);
        send_event(hra_pkg::EV_MINIMUM, 40'd120);
        send_event(hra_pkg::EV_MODULATION, 40'd150);
        send_event(hra_pkg::EV_MINIMUM, 40'd160);
        send_event(hra_pkg::EV_PELLET_ON, 40'd170);
        send_event(hra_pkg::EV_GAS_ON, 40'd180);
        send_event(hra_pkg::EV_GAS_OFF, 40'd200);
        send_event(EV_UNUSED_LO, 40'd210);
        send_event(EV_UNUSED_HI, 40'd215);
        w = base_word(OP_UNUSED, 40'd220);
        send_word(w);
        send_event(hra_pkg::EV_PELLET_OFF, 40'd230);
        send_finish(40'd240);
        pause_until_drained();
    endtask

    // A hot burner closes the gas span and blocks gas-on until it cools down.
    task automatic test_hot_gating();
        send_start(40'd1000, 1'b0, 1'b0, 1'b1, 32'd5, 32'd6, 32'd7);
        send_event(hra_pkg::EV_HOT, 40'd1010);
        send_event(hra_pkg::EV_GAS_ON, 40'd1020);
        send_event(hra_pkg::EV_COLD, 40'd1030);
        send_event(hra_pkg::EV_GAS_ON, 40'd1040);
        send_finish(40'd1050);
        pause_until_drained();
    endtask

    // Stamp and total extremes: start at zero, time running backwards, saturation,
    // and events after a finish.
    task automatic test_extremes();
        send_start(40'd0, 1'b1, 1'b1, 1'b1, TOTAL_MAX, TOTAL_MAX, TOTAL_MAX);
        send_event(hra_pkg::EV_PELLET_ON, 40'd1);
        send_finish(STAMP_MAX);
        send_start(STAMP_MAX, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0, 32'd0);
        send_finish(40'd5);
        send_start(40'd1, 1'b1, 1'b1, 1'b1, 32'd0, 32'd1, TOTAL_MAX - 1);
        send_finish(STAMP_MAX);
        send_event(hra_pkg::EV_PELLET_OFF, 40'd9);
        send_finish(40'd10);
        pause_until_drained();
    endtask

    function automatic logic [STAMP_W-1:0] random_stamp();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            return '0;
        end else if (pick < 20) begin
            return STAMP_MAX - STAMP_W'($urandom_range(0, 5000));
        end
        return {8'($urandom_range(0, 255)), 32'($urandom())};
    endfunction

    // Next event stamp: mostly forward by seconds to hours, sometimes a span wider
    // than the totals, sometimes backwards or a fresh stamp.
    function automatic logic [STAMP_W-1:0] advance(input logic [STAMP_W-1:0] stamp);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return stamp + STAMP_W'($urandom_range(0, 3600));
        end else if (pick < 80) begin
            return stamp + STAMP_W'($urandom_range(0, 15));
        end else if (pick < 88) begin
            return stamp + {6'd0, 2'($urandom_range(0, 3)), 32'($urandom())};
        end else if (pick < 95) begin
            return stamp - STAMP_W'($urandom_range(0, 500));
        end
        return random_stamp();
    endfunction

    function automatic logic [TOTAL_W-1:0] random_total();
        if ($urandom_range(0, 99) < 15) begin
            return TOTAL_MAX - TOTAL_W'($urandom_range(0, 5000));
        end
        return $urandom();
    endfunction

    // Mostly well-formed intervals with random content, mixed with loose words of any
    // operation. The first stretch runs without sender gaps.
    task automatic test_random_intervals(input int word_goal);
        logic [STAMP_W-1:0] stamp;
        t_heater_word       w;
        int                 events;
        int                 goal;
        goal          = busy_words + word_goal;
        sender_steady = 1'b1;
        while (busy_words < goal) begin
            if (busy_words > goal - (word_goal * 3) / 4) begin
                sender_steady = 1'b0;
            end
            if ($urandom_range(0, 99) < 85) begin
                stamp = random_stamp();
                send_start(stamp, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), random_total(), random_total(),
                           random_total());
                events = $urandom_range(0, 14);
                repeat (events) begin
                    stamp = advance(stamp);
                    if ($urandom_range(0, 9) == 0) begin
                        send_event(4'($urandom_range(EV_UNUSED_LO, EV_UNUSED_HI)), stamp);
                    end else begin
                        send_event(4'($urandom_range(0, EV_UNUSED_LO - 1)), stamp);
                    end
                end
                send_finish(advance(stamp));
            end else begin
                w = base_word(2'($urandom_range(0, 3)), random_stamp());
                send_word(w);
            end
            if ($urandom_range(0, 19) == 0) begin
                pause_until_drained();
            end
        end
    endtask

    // Receiver stall pattern: alternates between always ready, random stalls, short
    // periodic stalls and long stalls.
    always @(negedge i_clk) begin
        if (pace_left == 0) begin
            pace_mode = $urandom_range(0, 3);
            pace_left = $urandom_range(16, 80);
        end
        pace_left--;
        case (pace_mode)
            0:       i_ready = 1'b1;
            1:       i_ready = ($urandom_range(0, 2) != 0);
            2:       i_ready = ((pace_left % 7) >= 3);
            default: i_ready = ((pace_left % 16) >= 10);
        endcase
    end

    task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // Compare every accepted result word with the oldest pending prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_totals.size() == 0) begin
                $error("result word with no expected totals pending");
                error_count++;
            end else begin
                oldest_totals = pending_totals.pop_front();
                check_field("pellet_total", oldest_totals.pellet_total, o_pellet_total);
                check_field("low_total", oldest_totals.low_total, o_low_total);
                check_field("gas_total", oldest_totals.gas_total, o_gas_total);
                check_field("pellet_still_on", TOTAL_W'(oldest_totals.pellet_lit),
                            TOTAL_W'(o_pellet_still_on));
                check_field("low_still_on", TOTAL_W'(oldest_totals.low_on),
                            TOTAL_W'(o_low_still_on));
                check_field("gas_still_on", TOTAL_W'(oldest_totals.gas_on),
                            TOTAL_W'(o_gas_still_on));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        i_valid             = 1'b0;
        i_ready             = 1'b0;
        i_operation         = hra_pkg::OP_START;
        i_stamp             = '0;
        i_event_code        = hra_pkg::EV_GAS_ON;
        i_init_pellet_on    = 1'b0;
        i_init_pellet_low   = 1'b0;
        i_init_gas_on       = 1'b0;
        i_init_pellet_total = '0;
        i_init_low_total    = '0;
        i_init_gas_total    = '0;
        gas_open_at         = '0;
        pellet_open_at      = '0;
        low_open_at         = '0;
        burner_hot          = 1'b0;
        pellet_sum          = '0;
        low_sum             = '0;
        gas_sum             = '0;
        error_count         = 0;
        cycle_count         = 0;
        burst_left          = 0;
        sender_steady       = 1'b0;
        busy_words          = 0;
        pace_mode           = 0;
        pace_left           = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_without_start();
        test_event_codes();
        test_hot_gating();
        test_extremes();
        test_random_intervals(1000);

        // Let the last results drain, then watch for stray words.
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_totals.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
